[sv/assert_macros.svh]
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk, off while in reset
`define KWG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never be seen on a rising edge of clk
`define KWG_ASSERT_NEVER(lbl, cond, msg) \
	`KWG_ASSERT(lbl, !(cond), msg)

`endif

[sv/kwg_pkg.sv]
// types, constants and table functions of the keypad waveform generator
`timescale 1ns / 1ps
`default_nettype none

package kwg_pkg;

	localparam int unsigned TABLE_DEPTH = 2640;
	localparam int unsigned BASE_PERIOD = 400000;

	localparam int IDX_W   = $clog2(TABLE_DEPTH);
	localparam int PER_W   = $clog2(BASE_PERIOD + 1);
	localparam int LEVEL_W = 12;
	localparam int WAVE_W  = 2;
	localparam int KEY_W   = 4;
	localparam int STEP_W  = 3;
	localparam int DUTY_W  = 4;
	localparam int TPS_W   = 16;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 1;

	// divide by ten as multiply by reciprocal, exact for products below 2^23
	localparam int PD_W        = PER_W + DUTY_W;
	localparam int RECIP_SHIFT = 26;
	localparam int unsigned RECIP_DIV10 = ((2 ** RECIP_SHIFT) + 9) / 10;
	localparam int RECIP_W     = $clog2(RECIP_DIV10 + 1);
	localparam int PROD_W      = PD_W + RECIP_W;

	// wave codes
	localparam logic [WAVE_W-1:0] WAVE_SINE   = 2'd0;
	localparam logic [WAVE_W-1:0] WAVE_TRI    = 2'd1;
	localparam logic [WAVE_W-1:0] WAVE_SAW    = 2'd2;
	localparam logic [WAVE_W-1:0] WAVE_SQUARE = 2'd3;

	// item kinds
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_KEY  = 1'b1;

	// key codes
	localparam logic [KEY_W-1:0] KEY_STEP_LO = 4'd1;
	localparam logic [KEY_W-1:0] KEY_STEP_HI = 4'd5;
	localparam logic [KEY_W-1:0] KEY_SINE    = 4'd6;
	localparam logic [KEY_W-1:0] KEY_SQUARE  = 4'd9;
	localparam logic [KEY_W-1:0] KEY_STAR    = 4'd10;
	localparam logic [KEY_W-1:0] KEY_POUND   = 4'd11;
	localparam logic [KEY_W-1:0] KEY_ZERO    = 4'd12;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TPS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH = 1'd1;

	// reset values
	localparam logic [TPS_W-1:0]   TPS_RST  = 16'd152;
	localparam logic [LEVEL_W-1:0] HIGH_RST = 12'd3000;
	localparam logic [STEP_W-1:0]  STEP_RST = 3'd1;
	localparam logic [DUTY_W-1:0]  DUTY_RST = 4'd5;
	localparam logic [DUTY_W-1:0]  DUTY_MIN = 4'd1;
	localparam logic [DUTY_W-1:0]  DUTY_MAX = 4'd9;
	localparam logic [PER_W-1:0]   SQ_PERIOD_RST  = PER_W'(BASE_PERIOD);
	localparam logic [PER_W-1:0]   SQ_COMPARE_RST = PER_W'(BASE_PERIOD * 5 / 10);

	// table arithmetic
	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] PI_Q30      = 64'd3373259426;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] SINE_MID    = 64'd1475;
	localparam logic [63:0] LEVEL_MAX   = 64'd4095;
	localparam logic [31:0] SLOPE_Q16   = 32'd74558;
	localparam logic [31:0] TRI_TOP_Q16 = 32'(6000 * 65536);

	typedef struct packed {
		logic             cmd;
		logic [KEY_W-1:0] key;
	} evt_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [WAVE_W-1:0]  wave;
	} smp_t;

	// controller to datapath
	typedef struct packed {
		logic do_tick;
		logic do_key;
		logic load_sample;
		logic duty_mul;
		logic duty_div;
	} kwg_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_room;
		logic sample_due;
		logic key_cmp;
	} kwg_sts_t;

	function automatic logic [LEVEL_W-1:0] sat_level(input logic [63:0] v);
		return (v > LEVEL_MAX) ? LEVEL_W'(LEVEL_MAX) : LEVEL_W'(v);
	endfunction

	// q30 taylor series, products truncated, but the negative half is rounded up
	function automatic logic [LEVEL_W-1:0] sine_level(input int unsigned i);
		logic [63:0] a;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] m;
		logic [63:0] d;
		logic        neg;
		a = (64'(i) * (64'd2 * PI_Q30)) / 64'(TABLE_DEPTH);
		neg = 1'b0;
		if (a >= PI_Q30) begin
			a = a - PI_Q30;
			neg = 1'b1;
		end
		if (a > HALF_PI_Q30) a = PI_Q30 - a;
		x2 = (a * a) >> 30;
		t = Q30_ONE;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
		s = (a * t) >> 30;
		m = SINE_MID * s;
		if (!neg) return sat_level(SINE_MID + (m >> 30));
		d = (m + Q30_ONE - 64'd1) >> 30;
		if (d > SINE_MID) d = SINE_MID;
		return LEVEL_W'(SINE_MID - d);
	endfunction

	function automatic logic [LEVEL_W-1:0] saw_level(input logic [IDX_W-1:0] idx);
		logic [31:0] p;
		p = 32'(idx) * SLOPE_Q16;
		return sat_level(64'(p >> 16));
	endfunction

	function automatic logic [LEVEL_W-1:0] tri_level(input logic [IDX_W-1:0] idx);
		logic [31:0] p;
		p = 32'(idx) * (SLOPE_Q16 << 1);
		if (32'(idx) <= 32'(TABLE_DEPTH / 2)) return sat_level(64'(p >> 16));
		if (p >= TRI_TOP_Q16) return '0;
		return sat_level(64'((TRI_TOP_Q16 - p) >> 16));
	endfunction

	function automatic logic [PER_W-1:0] period_of(input logic [STEP_W-1:0] step);
		logic [PER_W-1:0] p;
		case (step)
			3'd2:    p = PER_W'(BASE_PERIOD / 2);
			3'd3:    p = PER_W'(BASE_PERIOD / 3);
			3'd4:    p = PER_W'(BASE_PERIOD / 4);
			3'd5:    p = PER_W'(BASE_PERIOD / 5);
			default: p = PER_W'(BASE_PERIOD);
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

[sv/kwg_ctrl.sv]
// controller state machine of the keypad waveform generator
`timescale 1ns / 1ps
`default_nettype none

module kwg_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             evt_valid,
	input  wire logic             evt_cmd,
	input  wire kwg_pkg::kwg_sts_t sts,
	output logic                  evt_stall,
	output kwg_pkg::kwg_cmd_t     ctl
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SAMPLE = 2'd1;
	localparam logic [1:0] ST_MUL    = 2'd2;
	localparam logic [1:0] ST_DIV    = 2'd3;

	logic [1:0] st_q;
	logic [1:0] st_nxt;
	logic       accept;

	assign evt_stall = !((st_q == ST_IDLE) && sts.out_room);
	assign accept    = evt_valid && !evt_stall;

	always_comb begin
		ctl.do_tick     = accept && (evt_cmd == kwg_pkg::CMD_TICK);
		ctl.do_key      = accept && (evt_cmd == kwg_pkg::CMD_KEY);
		ctl.load_sample = (st_q == ST_SAMPLE);
		ctl.duty_mul    = (st_q == ST_MUL);
		ctl.duty_div    = (st_q == ST_DIV);
	end

	always_comb begin
		unique case (st_q)
			ST_IDLE: begin
				priority if (ctl.do_tick && sts.sample_due) st_nxt = ST_SAMPLE;
				else if (ctl.do_key && sts.key_cmp) st_nxt = ST_MUL;
				else st_nxt = ST_IDLE;
			end
			ST_SAMPLE: st_nxt = ST_IDLE;
			ST_MUL:    st_nxt = ST_DIV;
			ST_DIV:    st_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_nxt;
		end
	end

endmodule

`default_nettype wire

[sv/kwg_dp.sv]
// datapath of the keypad waveform generator: timers, sine rom, duty arithmetic
`timescale 1ns / 1ps
`default_nettype none

module kwg_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [kwg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [kwg_pkg::CFG_W-1:0]          cfg_data,
	input  wire kwg_pkg::evt_t                      evt,
	input  wire kwg_pkg::kwg_cmd_t                  ctl,
	output kwg_pkg::kwg_sts_t                       sts,
	output logic                                    smp_valid,
	input  wire logic                               smp_stall,
	output kwg_pkg::smp_t                           smp
);

	// millivolt sine table, read through rom_q
	logic [kwg_pkg::LEVEL_W-1:0] sine_rom [kwg_pkg::TABLE_DEPTH];

	// configuration
	logic [kwg_pkg::TPS_W-1:0]   tps_q;
	logic [kwg_pkg::LEVEL_W-1:0] high_q;

	// generator state
	logic [kwg_pkg::WAVE_W-1:0]  mode_q;
	logic [kwg_pkg::STEP_W-1:0]  step_q;
	logic [kwg_pkg::DUTY_W-1:0]  duty_q;
	logic [kwg_pkg::IDX_W-1:0]   index_q;
	logic [kwg_pkg::TPS_W-1:0]   timer_q;
	logic [kwg_pkg::PER_W-1:0]   counter_q;
	logic [kwg_pkg::PER_W-1:0]   period_q;
	logic [kwg_pkg::PER_W-1:0]   compare_q;

	logic [kwg_pkg::LEVEL_W-1:0] rom_q;
	logic [kwg_pkg::PD_W-1:0]    pd_s1;
	logic                        smp_valid_q;
	kwg_pkg::smp_t               smp_q;

	logic                        is_sq;
	logic                        is_step_key;
	logic                        is_wave_key;
	logic                        is_duty_key;
	logic                        wave_change;
	logic [kwg_pkg::WAVE_W-1:0]  target;
	logic [kwg_pkg::DUTY_W-1:0]  duty_nxt;
	logic [kwg_pkg::TPS_W:0]     timer_inc;
	logic [kwg_pkg::PER_W:0]     counter_inc;
	logic [kwg_pkg::PER_W-1:0]   counter_nxt;
	logic [kwg_pkg::IDX_W:0]     index_lim;
	logic [kwg_pkg::IDX_W-1:0]   index_nxt;
	logic [kwg_pkg::PROD_W-1:0]  div_prod;
	logic [kwg_pkg::LEVEL_W-1:0] table_level;
	logic                        sq_hit;
	logic                        emit;
	kwg_pkg::smp_t               smp_nxt;

	// table contents fixed at start-up
	initial begin
		for (int unsigned i = 0; i < kwg_pkg::TABLE_DEPTH; i++)
			sine_rom[kwg_pkg::IDX_W'(i)] = kwg_pkg::sine_level(i);
	end

	// key decode
	always_comb begin
		is_sq       = (mode_q == kwg_pkg::WAVE_SQUARE);
		is_step_key = (evt.key >= kwg_pkg::KEY_STEP_LO) &&
			(evt.key <= kwg_pkg::KEY_STEP_HI);
		is_wave_key = (evt.key >= kwg_pkg::KEY_SINE) && (evt.key <= kwg_pkg::KEY_SQUARE);
		target      = kwg_pkg::WAVE_W'(evt.key - kwg_pkg::KEY_SINE);
		wave_change = is_wave_key && (target != mode_q);
		is_duty_key = is_sq && ((evt.key == kwg_pkg::KEY_STAR) ||
			(evt.key == kwg_pkg::KEY_POUND) || (evt.key == kwg_pkg::KEY_ZERO));
		priority if (evt.key == kwg_pkg::KEY_STAR) begin
			duty_nxt = (duty_q > kwg_pkg::DUTY_MIN) ? duty_q - kwg_pkg::DUTY_W'(1) : duty_q;
		end else if (evt.key == kwg_pkg::KEY_POUND) begin
			duty_nxt = (duty_q < kwg_pkg::DUTY_MAX) ? duty_q + kwg_pkg::DUTY_W'(1) : duty_q;
		end else begin
			duty_nxt = kwg_pkg::DUTY_RST;
		end
	end

	// tick arithmetic
	always_comb begin
		timer_inc   = {1'b0, timer_q} + (kwg_pkg::TPS_W + 1)'(1);
		counter_inc = {1'b0, counter_q} + (kwg_pkg::PER_W + 1)'(1);
		counter_nxt = (counter_inc >= {1'b0, period_q}) ? '0 :
			counter_inc[kwg_pkg::PER_W-1:0];
		index_lim   = (kwg_pkg::IDX_W + 1)'(kwg_pkg::TABLE_DEPTH) -
			(kwg_pkg::IDX_W + 1)'(step_q);
		index_nxt   = ({1'b0, index_q} >= index_lim) ? '0 : index_q + kwg_pkg::IDX_W'(step_q);
		div_prod    = kwg_pkg::PROD_W'(pd_s1) * kwg_pkg::PROD_W'(kwg_pkg::RECIP_DIV10);
		sq_hit      = (counter_q == '0) || (counter_q == compare_q);
	end

	always_comb begin
		unique case (mode_q)
			kwg_pkg::WAVE_SINE: table_level = rom_q;
			kwg_pkg::WAVE_TRI:  table_level = kwg_pkg::tri_level(index_q);
			default:            table_level = kwg_pkg::saw_level(index_q);
		endcase
		emit = ctl.load_sample || (ctl.do_tick && is_sq && sq_hit);
		if (ctl.load_sample) begin
			smp_nxt.level = table_level;
			smp_nxt.wave  = mode_q;
		end else begin
			smp_nxt.level = (counter_q == '0) ? high_q : '0;
			smp_nxt.wave  = kwg_pkg::WAVE_SQUARE;
		end
	end

	always_comb begin
		sts.out_room   = !smp_valid_q || !smp_stall;
		sts.sample_due = !is_sq && (timer_inc >= {1'b0, tps_q});
		sts.key_cmp    = (is_step_key && is_sq) ||
			(wave_change && (target == kwg_pkg::WAVE_SQUARE)) || is_duty_key;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q       <= kwg_pkg::TPS_RST;
			high_q      <= kwg_pkg::HIGH_RST;
			mode_q      <= kwg_pkg::WAVE_SQUARE;
			step_q      <= kwg_pkg::STEP_RST;
			duty_q      <= kwg_pkg::DUTY_RST;
			index_q     <= '0;
			timer_q     <= '0;
			counter_q   <= '0;
			period_q    <= kwg_pkg::SQ_PERIOD_RST;
			compare_q   <= kwg_pkg::SQ_COMPARE_RST;
			smp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					kwg_pkg::CFG_TPS:  tps_q  <= cfg_data;
					kwg_pkg::CFG_HIGH: high_q <= cfg_data[kwg_pkg::LEVEL_W-1:0];
				endcase
			end
			if (ctl.do_key) begin
				priority if (is_step_key) begin
					step_q <= evt.key[kwg_pkg::STEP_W-1:0];
					if (is_sq) period_q <= kwg_pkg::period_of(evt.key[kwg_pkg::STEP_W-1:0]);
				end else if (wave_change) begin
					mode_q <= target;
					if (target == kwg_pkg::WAVE_SQUARE) begin
						counter_q <= '0;
						period_q  <= kwg_pkg::period_of(step_q);
					end else begin
						index_q <= '0;
						timer_q <= '0;
					end
				end else if (is_duty_key) begin
					duty_q <= duty_nxt;
				end
			end
			if (ctl.do_tick) begin
				priority if (is_sq) begin
					counter_q <= counter_nxt;
				end else if (sts.sample_due) begin
					timer_q <= '0;
				end else begin
					timer_q <= timer_inc[kwg_pkg::TPS_W-1:0];
				end
			end
			if (ctl.load_sample) index_q <= index_nxt;
			if (ctl.duty_div) compare_q <= div_prod[kwg_pkg::RECIP_SHIFT +: kwg_pkg::PER_W];
			if (emit) begin
				smp_valid_q <= 1'b1;
			end else if (!smp_stall) begin
				smp_valid_q <= 1'b0;
			end
		end
	end

	// sine rom read and payload registers
	always_ff @(posedge clk) begin
		rom_q <= sine_rom[index_q];
		if (ctl.duty_mul) pd_s1 <= kwg_pkg::PD_W'(period_q) * kwg_pkg::PD_W'(duty_q);
		if (emit) smp_q <= smp_nxt;
	end

	assign smp_valid = smp_valid_q;
	assign smp       = smp_q;

endmodule

`default_nettype wire

[sv/keypad_waveform_generator_unit.sv]
// top level of the keypad waveform generator
//
//  channel  direction  handshake            payload
//  evt      in         evt_valid/evt_stall  cmd (tick or key), key code
//  smp      out        smp_valid/smp_stall  level in millivolts, wave code
//  cfg      in         cfg_we               cfg_index, cfg_data
//
// a square tick, a table tick with no sample due and most keys finish when accepted
// a table tick that yields a sample: accept, then output register load in the sample state
// a key that changes the square period or duty: accept, then period times duty,
//   then the divide by ten as a reciprocal multiply
// reset loads the configuration and wave state with their start values; the sine rom
//   is a fixed table and needs no clearing
// evt_stall is high while an item is in progress or a held result fills the output register
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module keypad_waveform_generator_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [kwg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [kwg_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          evt_valid,
	output logic                               evt_stall,
	input  wire kwg_pkg::evt_t                 evt,
	output logic                               smp_valid,
	input  wire logic                          smp_stall,
	output kwg_pkg::smp_t                      smp
);

	// command and status between controller and datapath
	kwg_pkg::kwg_cmd_t ctl;
	kwg_pkg::kwg_sts_t sts;
	logic [4:0]        ctl_flags;

	// sequencing: accept, sample load, duty multiply and divide
	kwg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_cmd   (evt.cmd),
		.sts       (sts),
		.evt_stall (evt_stall),
		.ctl       (ctl)
	);

	// wave state, sine rom, square counter and the output register
	kwg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.evt       (evt),
		.ctl       (ctl),
		.sts       (sts),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp       (smp)
	);

	// all datapath commands side by side
	assign ctl_flags = {ctl.do_tick, ctl.do_key, ctl.load_sample,
		ctl.duty_mul, ctl.duty_div};

	// a key that needs the duty arithmetic holds off the next item
	`KWG_ASSERT(a_key_holds_off, (ctl.do_key && sts.key_cmp) |=> evt_stall, "key item not held off")
	// a sample load always leaves a result in the output register
	`KWG_ASSERT(a_sample_emits, ctl.load_sample |=> smp_valid, "sample load gave no result")
	// the reciprocal multiply follows the duty multiply
	`KWG_ASSERT(a_mul_then_div, ctl.duty_mul |=> ctl.duty_div, "duty divide step skipped")
	// at most one datapath command in a cycle
	`KWG_ASSERT_NEVER(a_one_command, !$onehot0(ctl_flags), "overlapping datapath commands")

endmodule

`default_nettype wire
